@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/prcu_pkg.sv @@
package prcu_pkg;

  localparam int PLANE_COUNT_MAX_DEF = 4;
  localparam int COMPARE_ENTRIES_DEF = 8;
  localparam int NUM_PLANES          = 4;
  localparam int CC_ENTRY_W          = 4;

  localparam logic [2:0]  PLANE_COUNT_RST    = 3'd3;
  localparam logic [31:0] COMPARE_COLORS_RST = 32'h8888_8888;

  typedef enum logic [2:0] {
    OP_PSET    = 3'd0,
    OP_BLANK   = 3'd1,
    OP_OR      = 3'd2,
    OP_AND     = 3'd3,
    OP_XOR     = 3'd4,
    OP_NOT     = 3'd5,
    OP_TILE    = 3'd6,
    OP_COMPARE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    CFG_PLANE_COUNT    = 3'd0,
    CFG_COLOR_SELECT   = 3'd1,
    CFG_KEEP_MASK      = 3'd2,
    CFG_PLANE_DISABLE  = 3'd3,
    CFG_TILE_PATTERN   = 3'd4,
    CFG_COMPARE_COLORS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic load_b;
    logic load_c;
  } pipe_ctl_t;

  function automatic logic [7:0] rop_byte(op_t op, logic c, logic [7:0] o, logic [7:0] tile);
    logic [7:0] v;
    case (op)
      OP_PSET:  v = c ? 8'hff : 8'h00;
      OP_BLANK: v = 8'h00;
      OP_OR:    v = c ? 8'hff : o;
      OP_AND:   v = c ? o : 8'h00;
      OP_XOR:   v = c ? ~o : o;
      OP_NOT:   v = ~o;
      OP_TILE:  v = tile;
      default:  v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/prcu_compare.sv @@
module prcu_compare #(
  parameter int COMPARE_ENTRIES = prcu_pkg::COMPARE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  prcu_pkg::pipe_ctl_t ctl,
  input  logic                a_is_cmp,
  input  logic [7:0]          pix_blue,
  input  logic [7:0]          pix_red,
  input  logic [7:0]          pix_green,
  input  logic [2:0]          plane_disable,
  input  logic [31:0]         compare_colors,
  output logic [7:0]          match_next
);
  import prcu_pkg::*;

  logic [7:0][COMPARE_ENTRIES-1:0] hit;
  logic [7:0][COMPARE_ENTRIES-1:0] b_hit;
  logic                            b_is_cmp;
  logic [7:0]                      match_status;
  logic [7:0]                      reduced;

  // pixel vs entry equality, masked by enabled planes; an entry with its top bit set never hits
  always_comb begin
    logic [2:0]            en;
    logic [2:0]            pix;
    logic [CC_ENTRY_W-1:0] entry;
    en = ~plane_disable;
    for (int px = 0; px < 8; px++) begin
      pix = {pix_green[px], pix_red[px], pix_blue[px]} & en;
      for (int j = 0; j < COMPARE_ENTRIES; j++) begin
        entry = compare_colors[CC_ENTRY_W*j +: CC_ENTRY_W];
        hit[px][j] = !entry[CC_ENTRY_W-1] && ((entry[2:0] & en) == pix);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      b_hit    <= hit;
      b_is_cmp <= a_is_cmp;
    end
  end

  always_comb begin
    for (int px = 0; px < 8; px++) begin
      reduced[px] = |b_hit[px];
    end
    match_next = b_is_cmp ? reduced : match_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_status <= 8'h00;
    end else if (ctl.load_c) begin
      match_status <= match_next;
    end
  end

endmodule

@@ rtl/planar_raster_op_compare_unit.sv @@
// An input transfer is registered in stage A, then stage B, then the output register (stage C).
// Throughput: one item per cycle while the output is not stalled; three register stages, each
// advancing when the next one is empty or moving, so a stall on the output backs up without loss.
// Reset (rst, synchronous): pipeline empty, match status zero, registers at their
// defaults (plane_count 3, compare_colors 0x88888888, all others zero).
module planar_raster_op_compare_unit #(
  parameter int PLANE_COUNT_MAX = prcu_pkg::PLANE_COUNT_MAX_DEF,
  parameter int COMPARE_ENTRIES = prcu_pkg::COMPARE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [14:0] address,
  input  logic [7:0]  old_plane0,
  input  logic [7:0]  old_plane1,
  input  logic [7:0]  old_plane2,
  input  logic [7:0]  old_plane3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] write_address,
  output logic [7:0]  new_plane0,
  output logic [7:0]  new_plane1,
  output logic [7:0]  new_plane2,
  output logic [7:0]  new_plane3,
  output logic [3:0]  write_enable,
  output logic [7:0]  compare_status
);
  import prcu_pkg::*;

  logic [2:0]  plane_count;
  logic [3:0]  color_select;
  logic [7:0]  keep_mask;
  logic [3:0]  plane_disable;
  logic [31:0] tile_pattern;
  logic [31:0] compare_colors;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count    <= PLANE_COUNT_RST;
      color_select   <= '0;
      keep_mask      <= '0;
      plane_disable  <= '0;
      tile_pattern   <= '0;
      compare_colors <= COMPARE_COLORS_RST;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PLANE_COUNT:    plane_count    <= cfg_data[2:0];
        CFG_COLOR_SELECT:   color_select   <= cfg_data[3:0];
        CFG_KEEP_MASK:      keep_mask      <= cfg_data[7:0];
        CFG_PLANE_DISABLE:  plane_disable  <= cfg_data[3:0];
        CFG_TILE_PATTERN:   tile_pattern   <= cfg_data;
        CFG_COMPARE_COLORS: compare_colors <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic      a_valid;
  logic      b_valid;
  logic      a_ready;
  logic      b_ready;
  logic      c_ready;
  pipe_ctl_t ctl;

  assign c_ready    = !out_valid || !out_stall;
  assign b_ready    = !b_valid || c_ready;
  assign a_ready    = !a_valid || b_ready;
  assign in_stall   = !a_ready;
  assign ctl.load_b = b_ready && a_valid;
  assign ctl.load_c = c_ready && b_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  // stage A: captured input
  op_t                             a_opcode;
  logic [14:0]                     a_address;
  logic [NUM_PLANES-1:0][7:0]      a_old;

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_opcode  <= op_t'(opcode);
      a_address <= address;
      a_old     <= {old_plane3, old_plane2, old_plane1, old_plane0};
    end
  end

  logic [2:0]                 cnt_clip;
  logic [NUM_PLANES-1:0]      plane_en;
  logic [NUM_PLANES-1:0][7:0] op_byte;

  always_comb begin
    cnt_clip = (plane_count > 3'(PLANE_COUNT_MAX)) ? 3'(PLANE_COUNT_MAX) : plane_count;
    for (int i = 0; i < NUM_PLANES; i++) begin
      plane_en[i] = (3'(i) < cnt_clip) && !plane_disable[i] && (a_opcode != OP_COMPARE);
      op_byte[i]  = rop_byte(a_opcode, color_select[i], a_old[i], tile_pattern[8*i +: 8]);
    end
  end

  // stage B: operation bytes
  logic [14:0]                b_address;
  logic [NUM_PLANES-1:0]      b_we;
  logic [NUM_PLANES-1:0][7:0] b_op;
  logic [NUM_PLANES-1:0][7:0] b_old;
  logic [NUM_PLANES-1:0][7:0] merged;
  logic [7:0]                 match_next;

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      b_address <= a_address;
      b_we      <= plane_en;
      b_op      <= op_byte;
      b_old     <= a_old;
    end
  end

  prcu_compare #(
    .COMPARE_ENTRIES(COMPARE_ENTRIES)
  ) u_compare (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .a_is_cmp       (a_opcode == OP_COMPARE),
    .pix_blue       (a_old[0]),
    .pix_red        (a_old[1]),
    .pix_green      (a_old[2]),
    .plane_disable  (plane_disable[2:0]),
    .compare_colors (compare_colors),
    .match_next     (match_next)
  );

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      merged[i] = b_we[i] ? ((b_old[i] & keep_mask) | (b_op[i] & ~keep_mask)) : 8'h00;
    end
  end

  // stage C: output register
  always_ff @(posedge clk) begin
    if (ctl.load_c) begin
      write_address  <= b_address;
      new_plane0     <= merged[0];
      new_plane1     <= merged[1];
      new_plane2     <= merged[2];
      new_plane3     <= merged[3];
      write_enable   <= b_we;
      compare_status <= match_next;
    end
  end

endmodule

@@ rtl/prcu_checker.sv @@
`include "assert_macros.svh"

module prcu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [14:0] write_address,
  input logic [7:0]  new_plane0,
  input logic [7:0]  new_plane1,
  input logic [7:0]  new_plane2,
  input logic [7:0]  new_plane3,
  input logic [3:0]  write_enable,
  input logic [7:0]  compare_status
);

  `ASSERT_IMPLIES(a_unwritten_zero, clk, rst, out_valid, (write_enable[0] || new_plane0 == 8'h00) && (write_enable[1] || new_plane1 == 8'h00) && (write_enable[2] || new_plane2 == 8'h00) && (write_enable[3] || new_plane3 == 8'h00), "unwritten plane byte not zero")

  `ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(write_address) && $stable(compare_status) && $stable(write_enable), "stalled result changed")

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result valid right after reset")

endmodule

bind planar_raster_op_compare_unit prcu_checker u_prcu_checker (.*);

@@ verif/tb_planar_raster_op_compare_unit.sv @@
module tb_planar_raster_op_compare_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import prcu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 60;

  typedef struct packed {
    logic [2:0]  count;
    logic [3:0]  color;
    logic [7:0]  keep;
    logic [3:0]  disable_mask;
    logic [31:0] tile;
    logic [31:0] cmp_colors;
  } rop_cfg_t;

  typedef struct packed {
    op_t              op;
    logic [14:0]      addr;
    logic [3:0][7:0]  old;
  } rop_item_t;

  typedef struct packed {
    logic [14:0]      addr;
    logic [3:0][7:0]  planes;
    logic [3:0]       we;
    logic [7:0]       status;
  } plane_write_t;

  typedef struct packed {
    logic         fixed;
    plane_write_t res;
  } pinned_write_t;

  typedef struct packed {
    rop_cfg_t      cfg;
    rop_item_t     item;
    pinned_write_t pin;
  } table_row_t;

  localparam rop_cfg_t CFG_AT_RESET =
    {PLANE_COUNT_RST, 4'h0, 8'h00, 4'h0, 32'h0, COMPARE_COLORS_RST};

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  opcode;
  logic [14:0] address;
  logic [7:0]  old_plane0, old_plane1, old_plane2, old_plane3;
  logic        out_valid;
  logic        out_stall;
  logic [14:0] write_address;
  logic [7:0]  new_plane0, new_plane1, new_plane2, new_plane3;
  logic [3:0]  write_enable;
  logic [7:0]  compare_status;

  planar_raster_op_compare_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .address(address),
    .old_plane0(old_plane0), .old_plane1(old_plane1),
    .old_plane2(old_plane2), .old_plane3(old_plane3),
    .out_valid(out_valid), .out_stall(out_stall),
    .write_address(write_address),
    .new_plane0(new_plane0), .new_plane1(new_plane1),
    .new_plane2(new_plane2), .new_plane3(new_plane3),
    .write_enable(write_enable), .compare_status(compare_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  plane_write_t  expected_writes[$];
  pinned_write_t pinned_writes[$];
  table_row_t    stim_table[$];
  rop_cfg_t      cfg_shadow;
  rop_cfg_t      cfg_loaded;
  logic [7:0]    match_hold;
  int            mismatches = 0;
  int            cycles = 0;
  int            gap_pct = 0;
  int            stall_pct = 0;

  function automatic plane_write_t predict_plane_write(input rop_item_t it);
    plane_write_t r;
    int           cnt;
    logic [7:0]   o, v, hits;
    logic [2:0]   en, pix;
    logic         c;
    r = '0;
    r.addr = it.addr;
    if (it.op == OP_COMPARE) begin
      en = ~cfg_shadow.disable_mask[2:0];
      hits = '0;
      for (int px = 0; px < 8; px++) begin
        pix = {it.old[2][px], it.old[1][px], it.old[0][px]} & en;
        for (int j = 0; j < COMPARE_ENTRIES_DEF; j++)
          if (!cfg_shadow.cmp_colors[4*j+3] && ((cfg_shadow.cmp_colors[4*j +: 3] & en) == pix))
            hits[px] = 1'b1;
      end
      match_hold = hits;
    end else begin
      cnt = (cfg_shadow.count > PLANE_COUNT_MAX_DEF) ? PLANE_COUNT_MAX_DEF : cfg_shadow.count;
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (i < cnt && !cfg_shadow.disable_mask[i]) begin
          o = it.old[i];
          c = cfg_shadow.color[i];
          case (it.op)
            OP_PSET:  v = {8{c}};
            OP_BLANK: v = 8'h00;
            OP_OR:    v = c ? 8'hff : o;
            OP_AND:   v = c ? o : 8'h00;
            OP_XOR:   v = c ? ~o : o;
            OP_NOT:   v = ~o;
            default:  v = cfg_shadow.tile[8*i +: 8];
          endcase
          r.planes[i] = (o & cfg_shadow.keep) | (v & ~cfg_shadow.keep);
          r.we[i] = 1'b1;
        end
      end
    end
    r.status = match_hold;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t mismatch on %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // input side: register shadow and prediction per input transfer
  always @(posedge clk) begin
    rop_item_t     it;
    pinned_write_t pin;
    plane_write_t  r;
    if (rst) begin
      cfg_shadow = CFG_AT_RESET;
      match_hold = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PLANE_COUNT:    cfg_shadow.count = cfg_data[2:0];
          CFG_COLOR_SELECT:   cfg_shadow.color = cfg_data[3:0];
          CFG_KEEP_MASK:      cfg_shadow.keep = cfg_data[7:0];
          CFG_PLANE_DISABLE:  cfg_shadow.disable_mask = cfg_data[3:0];
          CFG_TILE_PATTERN:   cfg_shadow.tile = cfg_data;
          CFG_COMPARE_COLORS: cfg_shadow.cmp_colors = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        it.op = op_t'(opcode);
        it.addr = address;
        it.old = {old_plane3, old_plane2, old_plane1, old_plane0};
        r = predict_plane_write(it);
        if (pinned_writes.size() != 0) begin
          pin = pinned_writes.pop_front();
          if (pin.fixed)
            r = pin.res;
        end
        expected_writes.push_back(r);
      end
    end
  end

  // output side: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    plane_write_t seen, want;
    if (!rst && out_valid && !out_stall) begin
      seen = {write_address, new_plane3, new_plane2, new_plane1, new_plane0,
              write_enable, compare_status};
      if (expected_writes.size() == 0) begin
        flag_mismatch("result with nothing expected", 32'(seen.addr), 32'h0);
      end else begin
        want = expected_writes.pop_front();
        if (seen.addr !== want.addr)
          flag_mismatch("write_address", 32'(seen.addr), 32'(want.addr));
        for (int i = 0; i < NUM_PLANES; i++)
          if (seen.planes[i] !== want.planes[i])
            flag_mismatch($sformatf("new_plane%0d", i), 32'(seen.planes[i]),
                          32'(want.planes[i]));
        if (seen.we !== want.we)
          flag_mismatch("write_enable", 32'(seen.we), 32'(want.we));
        if (seen.status !== want.status)
          flag_mismatch("compare_status", 32'(seen.status), 32'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_planar_raster_op_compare_unit: errors");
      $finish;
    end
  end

  // valid stays high after a transfer unless a gap follows
  task automatic send_item(input rop_item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    opcode <= it.op;
    address <= it.addr;
    {old_plane3, old_plane2, old_plane1, old_plane0} <= it.old;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(input rop_cfg_t c);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PLANE_COUNT;    cfg_data <= 32'(c.count);        @(posedge clk);
    cfg_index <= CFG_COLOR_SELECT;   cfg_data <= 32'(c.color);        @(posedge clk);
    cfg_index <= CFG_KEEP_MASK;      cfg_data <= 32'(c.keep);         @(posedge clk);
    cfg_index <= CFG_PLANE_DISABLE;  cfg_data <= 32'(c.disable_mask); @(posedge clk);
    cfg_index <= CFG_TILE_PATTERN;   cfg_data <= c.tile;              @(posedge clk);
    cfg_index <= CFG_COMPARE_COLORS; cfg_data <= c.cmp_colors;        @(posedge clk);
    cfg_write <= 1'b0;
    cfg_loaded = c;
  endtask

  task automatic add_row(input rop_cfg_t c, input op_t op, input logic [14:0] a,
                         input logic [31:0] old, input logic fixed,
                         input plane_write_t res);
    table_row_t row;
    row.cfg = c;
    row.item.op = op;
    row.item.addr = a;
    row.item.old = old;
    row.pin.fixed = fixed;
    row.pin.res = res;
    stim_table.push_back(row);
  endtask

  function automatic rop_cfg_t random_cfg();
    rop_cfg_t c;
    c.count = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(3, 4)) : 3'($urandom_range(0, 7));
    c.color = 4'($urandom);
    case ($urandom_range(0, 3))
      0, 1:    c.keep = 8'h00;
      2:       c.keep = 8'($urandom);
      default: c.keep = 8'hff;
    endcase
    c.disable_mask = ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom);
    c.tile = $urandom;
    for (int j = 0; j < COMPARE_ENTRIES_DEF; j++)
      c.cmp_colors[4*j +: 4] = {($urandom_range(0, 3) == 0), 3'($urandom)};
    if ($urandom_range(0, 7) == 0)
      c.cmp_colors = 32'h8888_8888 | $urandom;
    return c;
  endfunction

  initial begin
    rop_cfg_t  cfg_b, cfg_c, cfg_d, cfg_e, c;
    rop_item_t it;

    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_PLANE_COUNT;
    cfg_data <= '0;
    in_valid <= 1'b0;
    opcode <= OP_PSET;
    address <= '0;
    {old_plane3, old_plane2, old_plane1, old_plane0} <= '0;
    cfg_loaded = CFG_AT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_b = {3'd4, 4'hf, 8'h00, 4'h0, 32'ha55a_0ff0, 32'h7654_3210};
    cfg_c = {3'd7, 4'h5, 8'hf0, 4'h8, 32'hffff_ffff, 32'h8888_8885};
    cfg_d = {3'd0, 4'ha, 8'h0f, 4'h7, 32'h0, 32'h0888_8888};
    cfg_e = {3'd2, 4'h3, 8'hff, 4'h0, 32'h0, 32'h0000_0007};

    // defaults after reset: three planes, color zero, no compare entry enabled
    add_row(CFG_AT_RESET, OP_PSET, 15'h0000, 32'hffff_ffff, 1'b1,
            {15'h0000, 32'h0, 4'h7, 8'h00});
    add_row(CFG_AT_RESET, OP_COMPARE, 15'h7fff, 32'h0, 1'b1,
            {15'h7fff, 32'h0, 4'h0, 8'h00});
    add_row(CFG_AT_RESET, OP_NOT, 15'h7fff, 32'h1234_5678, 1'b1,
            {15'h7fff, 32'h00cb_a987, 4'h7, 8'h00});
    // four planes, all colors set, every compare color enabled
    add_row(cfg_b, OP_PSET, 15'h1234, 32'h0, 1'b1, {15'h1234, 32'hffff_ffff, 4'hf, 8'h00});
    add_row(cfg_b, OP_BLANK, 15'h0001, 32'hffff_ffff, 1'b1, {15'h0001, 32'h0, 4'hf, 8'h00});
    add_row(cfg_b, OP_OR, 15'h4000, 32'h00ff_00ff, 1'b1,
            {15'h4000, 32'hffff_ffff, 4'hf, 8'h00});
    add_row(cfg_b, OP_AND, 15'h2aaa, 32'h5ac3_3c96, 1'b1,
            {15'h2aaa, 32'h5ac3_3c96, 4'hf, 8'h00});
    add_row(cfg_b, OP_XOR, 15'h5555, 32'h5ac3_3c96, 1'b1,
            {15'h5555, 32'ha53c_c369, 4'hf, 8'h00});
    add_row(cfg_b, OP_NOT, 15'h7ffe, 32'h0, 1'b1, {15'h7ffe, 32'hffff_ffff, 4'hf, 8'h00});
    add_row(cfg_b, OP_TILE, 15'h0100, 32'h1122_3344, 1'b1,
            {15'h0100, 32'ha55a_0ff0, 4'hf, 8'h00});
    add_row(cfg_b, OP_COMPARE, 15'h0200, 32'h00ff_0f33, 1'b1, {15'h0200, 32'h0, 4'h0, 8'hff});
    add_row(cfg_b, OP_PSET, 15'h0300, 32'h0, 1'b1, {15'h0300, 32'hffff_ffff, 4'hf, 8'hff});
    // count above the maximum, keep mask, plane 3 disabled, single compare color
    add_row(cfg_c, OP_PSET, 15'h0010, 32'h3c5a_a5c3, 1'b0, '0);
    add_row(cfg_c, OP_BLANK, 15'h0020, 32'hff00_ff00, 1'b0, '0);
    add_row(cfg_c, OP_OR, 15'h0030, 32'h0f0f_0f0f, 1'b0, '0);
    add_row(cfg_c, OP_AND, 15'h0040, 32'hf0f0_f0f0, 1'b0, '0);
    add_row(cfg_c, OP_XOR, 15'h0050, 32'h6699_33cc, 1'b0, '0);
    add_row(cfg_c, OP_NOT, 15'h0060, 32'h8001_7ffe, 1'b0, '0);
    add_row(cfg_c, OP_TILE, 15'h0070, 32'h1357_9bdf, 1'b0, '0);
    add_row(cfg_c, OP_COMPARE, 15'h0080, 32'h00f0_5a3c, 1'b0, '0);
    // zero planes; compare planes all masked so every pixel matches
    add_row(cfg_d, OP_COMPARE, 15'h6000, 32'h0f0f_0f0f, 1'b1, {15'h6000, 32'h0, 4'h0, 8'hff});
    add_row(cfg_d, OP_XOR, 15'h4000, 32'hffff_ffff, 1'b1, {15'h4000, 32'h0, 4'h0, 8'hff});
    // keep everything: new bytes equal old ones on two planes
    add_row(cfg_e, OP_TILE, 15'h0abc, 32'hdead_beef, 1'b1,
            {15'h0abc, 32'h0000_beef, 4'h3, 8'hff});
    add_row(cfg_e, OP_COMPARE, 15'h0def, 32'h00aa_ccf0, 1'b0, '0);

    gap_pct = 14;
    stall_pct = 86;
    foreach (stim_table[n]) begin
      if (stim_table[n].cfg != cfg_loaded) begin
        wait_drained();
        load_config(stim_table[n].cfg);
      end
      pinned_writes.push_back(stim_table[n].pin);
      send_item(stim_table[n].item);
    end

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0:       begin gap_pct = 14; stall_pct = 86; end
        1:       begin gap_pct = 86; stall_pct = 14; end
        default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      for (int chunk = 0; chunk < 6; chunk++) begin
        if (regime == 0 && chunk == 0)
          c = '1;
        else if (regime == 1 && chunk == 0)
          c = '0;
        else
          c = random_cfg();
        wait_drained();
        load_config(c);
        for (int k = 0; k < 102; k++) begin
          it.op = op_t'($urandom_range(0, 7));
          it.addr = 15'($urandom);
          it.old = $urandom;
          send_item(it);
        end
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0)
      $display("tb_planar_raster_op_compare_unit: clean");
    else
      $display("tb_planar_raster_op_compare_unit: errors");
    $finish;
  end

endmodule
